// File: rtl/point_to_box_feature_distance_macros.svh
// assertion macros for the point to box feature distance block
`ifndef POINT_TO_BOX_FEATURE_DISTANCE_MACROS_SVH
`define POINT_TO_BOX_FEATURE_DISTANCE_MACROS_SVH

// checked on every clock edge outside reset
`define PSBFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("psbfd assertion failed");

// checked on every clock edge, reset included
`define PSBFD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("psbfd assertion failed");

`endif

// File: rtl/psbfd_pkg.sv
// shared constants and types for the point to box feature distance block
package psbfd_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int NUM_AXES       = 3;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SIDE_MINUS  = 2'd0,
    SIDE_CENTER = 2'd1,
    SIDE_PLUS   = 2'd2
  } side_t;

endpackage

// File: rtl/psbfd_regs.sv
// box bound registers behind the configuration write port
module psbfd_regs
  import psbfd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  output logic signed [COORD_BITS-1:0] box_min [NUM_AXES],
  output logic signed [COORD_BITS-1:0] box_max [NUM_AXES]
);

  localparam logic [COORD_BITS-1:0] ONE_VAL = COORD_BITS'(64'(1) << FRAC_BITS);

  logic [COORD_BITS-1:0] min_r [NUM_AXES];
  logic [COORD_BITS-1:0] max_r [NUM_AXES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        min_r[a] <= '0;
        max_r[a] <= ONE_VAL;
      end
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX_MIN_X: min_r[0] <= cfg_data;
        REG_BOX_MIN_Y: min_r[1] <= cfg_data;
        REG_BOX_MIN_Z: min_r[2] <= cfg_data;
        REG_BOX_MAX_X: max_r[0] <= cfg_data;
        REG_BOX_MAX_Y: max_r[1] <= cfg_data;
        REG_BOX_MAX_Z: max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      box_min[a] = min_r[a];
      box_max[a] = max_r[a];
    end
  end

endmodule

// File: rtl/psbfd_front.sv
// gap, square and sum stages ahead of the square root
module psbfd_front
  import psbfd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int SW        = 2 * COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] point [NUM_AXES],
  input  logic [1:0]                   side [NUM_AXES],
  input  logic signed [COORD_BITS-1:0] box_min [NUM_AXES],
  input  logic signed [COORD_BITS-1:0] box_max [NUM_AXES],
  output logic                         sum_vld,
  output logic [SW-1:0]                sum
);

  logic                    gap_vld_r, sq_vld_r, sum_vld_r;
  logic [COORD_BITS-1:0]   gap_nxt [NUM_AXES];
  logic [COORD_BITS-1:0]   gap_r   [NUM_AXES];
  logic [2*COORD_BITS-1:0] sq_nxt  [NUM_AXES];
  logic [2*COORD_BITS-1:0] sq_r    [NUM_AXES];
  logic [SW-1:0]           sum_nxt;
  logic [SW-1:0]           sum_r;

  // gap fits COORD_BITS unsigned: |diff| is below 2^COORD_BITS
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [COORD_BITS:0] diff;
      logic signed [COORD_BITS-1:0] bound;
      logic active;
      active = 1'b1;
      bound  = box_max[a];
      case (side_t'(side[a]))
        SIDE_MINUS: bound = box_min[a];
        SIDE_PLUS:  bound = box_max[a];
        default:    active = 1'b0;
      endcase
      diff = (COORD_BITS+1)'(point[a]) - (COORD_BITS+1)'(bound);
      if (diff[COORD_BITS]) begin
        diff = -diff;
      end
      gap_nxt[a] = active ? diff[COORD_BITS-1:0] : '0;
      sq_nxt[a]  = (2*COORD_BITS)'(gap_r[a]) * (2*COORD_BITS)'(gap_r[a]);
    end
    sum_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_vld_r <= 1'b0;
      sq_vld_r  <= 1'b0;
      sum_vld_r <= 1'b0;
    end else if (en) begin
      gap_vld_r <= in_vld;
      sq_vld_r  <= gap_vld_r;
      sum_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        gap_r[a] <= gap_nxt[a];
        sq_r[a]  <= sq_nxt[a];
      end
      sum_r <= sum_nxt;
    end
  end

  assign sum_vld = sum_vld_r;
  assign sum     = sum_r;

endmodule

// File: rtl/psbfd_sqrt_stage.sv
// one result bit of the pipelined integer square root
module psbfd_sqrt_stage
  import psbfd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int BIT        = 0,
  localparam int SW        = 2 * COORD_BITS + 2,
  localparam int RW        = COORD_BITS + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [RW-1:0] root_in,
  input  logic [SW-1:0] rem_in,
  output logic          vld_out,
  output logic [RW-1:0] root_out,
  output logic [SW-1:0] rem_out
);

  logic          vld_r;
  logic [RW-1:0] root_r, root_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] trial;
  logic          take;

  // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b), the two parts never overlap
  always_comb begin
    trial    = (SW'(root_in) << (BIT + 1)) | (SW'(1) << (2 * BIT));
    take     = rem_in >= trial;
    root_nxt = take ? (root_in | (RW'(1) << BIT)) : root_in;
    rem_nxt  = take ? (rem_in - trial) : rem_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign root_out = root_r;
  assign rem_out  = rem_r;

endmodule

// File: rtl/point_to_box_feature_distance.sv
// pipeline: gap, square and sum registers, then one square root stage per result bit
// throughput: one word per cycle unless a waiting result is held by out_stall
// a stalled result holds the whole pipeline, so in_stall is out_stall while out_valid is high
// reset: synchronous active low, clears all valid bits, box min to 0 and box max to 1.0
// configuration writes are taken every cycle, cfg_ready is always high
`include "point_to_box_feature_distance_macros.svh"
module point_to_box_feature_distance
  import psbfd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  input  logic [1:0]                   in_side_x,
  input  logic [1:0]                   in_side_y,
  input  logic [1:0]                   in_side_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COORD_BITS:0]          out_feature_distance,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int SW = 2 * COORD_BITS + 2;
  localparam int RW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] point   [NUM_AXES];
  logic [1:0]                   side    [NUM_AXES];
  logic signed [COORD_BITS-1:0] box_min [NUM_AXES];
  logic signed [COORD_BITS-1:0] box_max [NUM_AXES];

  logic          en;
  logic          vld_c  [RW+1];
  logic [RW-1:0] root_c [RW+1];
  logic [SW-1:0] rem_c  [RW];

  assign point[0] = in_point_x;
  assign point[1] = in_point_y;
  assign point[2] = in_point_z;
  assign side[0]  = in_side_x;
  assign side[1]  = in_side_y;
  assign side[2]  = in_side_z;

  // the pipeline moves unless a finished word is waiting at the output
  assign en       = !(vld_c[RW] && out_stall);
  assign in_stall = !en;

  psbfd_regs #(.COORD_BITS(COORD_BITS)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_min   (box_min),
    .box_max   (box_max)
  );

  psbfd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .point   (point),
    .side    (side),
    .box_min (box_min),
    .box_max (box_max),
    .sum_vld (vld_c[0]),
    .sum     (rem_c[0])
  );

  assign root_c[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    if (k == RW - 1) begin : g_last
      psbfd_sqrt_stage #(.COORD_BITS(COORD_BITS), .BIT(RW - 1 - k)) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld_c[k]),
        .root_in  (root_c[k]),
        .rem_in   (rem_c[k]),
        .vld_out  (vld_c[k+1]),
        .root_out (root_c[k+1]),
        .rem_out  ()
      );
    end else begin : g_mid
      psbfd_sqrt_stage #(.COORD_BITS(COORD_BITS), .BIT(RW - 1 - k)) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld_c[k]),
        .root_in  (root_c[k]),
        .rem_in   (rem_c[k]),
        .vld_out  (vld_c[k+1]),
        .root_out (root_c[k+1]),
        .rem_out  (rem_c[k+1])
      );
    end
  end

  assign out_valid            = vld_c[RW];
  assign out_feature_distance = root_c[RW];

  // reset empties the pipeline
  `PSBFD_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid)
  // a word in the last root stage reaches the output when the pipe moves
  `PSBFD_ASSERT(a_last_advance, $past(rst_n) && $past(en) && $past(vld_c[RW-1]) |-> out_valid)
  // a moving pipe with an empty last root stage cannot raise the output from nothing
  `PSBFD_ASSERT(a_no_invent, $past(rst_n) && $past(en) && !$past(vld_c[RW-1]) |-> !out_valid)
  // a waiting result holds the input now and is still there next cycle
  `PSBFD_ASSERT(a_backpressure, out_valid && out_stall |-> in_stall ##1 out_valid)

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the point to box feature distance pipeline
`timescale 1ns / 1ps
module testbench;
  import psbfd_pkg::*;

  localparam int COORD_W      = COORD_BITS_DEF;
  localparam int LATENCY      = COORD_W + 4;
  localparam int NUM_BOX_REGS = 2 * NUM_AXES;
  localparam int HOLD_CYCLES  = 300;
  localparam int TIMEOUT_NS   = 5_000_000;

  localparam logic [1:0] SIDE_RESERVED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 3'd7;

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] FX_ONE    = COORD_W'(1 << FRAC_BITS);
  localparam logic signed [COORD_W-1:0] FX_HALF   = COORD_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [COORD_W-1:0] FX_QUART  = COORD_W'(1 << (FRAC_BITS - 2));

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [COORD_W-1:0]   in_point_x = '0;
  logic signed [COORD_W-1:0]   in_point_y = '0;
  logic signed [COORD_W-1:0]   in_point_z = '0;
  logic [1:0]                  in_side_x = SIDE_CENTER;
  logic [1:0]                  in_side_y = SIDE_CENTER;
  logic [1:0]                  in_side_z = SIDE_CENTER;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [COORD_W:0]            out_feature_distance;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
  logic [COORD_W-1:0]          cfg_data = '0;

  // local copy of the box registers
  logic signed [COORD_W-1:0]   box_bound [NUM_BOX_REGS];
  logic [COORD_W:0]            expected_dist_q [$];
  logic [COORD_W:0]            dist_want;

  int fail_count      = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int box_settings    = 0;
  int send_gap_pct    = 0;
  int recv_stall_pct  = 0;
  bit hold_pending    = 1'b0;

  point_to_box_feature_distance #(.COORD_BITS(COORD_W)) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_point_z           (in_point_z),
    .in_side_x            (in_side_x),
    .in_side_y            (in_side_y),
    .in_side_z            (in_side_z),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_feature_distance (out_feature_distance),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench NOT OK");
    $finish;
  end

  // floored root of the summed squared gaps over the non-center axes
  function automatic logic [COORD_W:0] box_feature_distance(
      input logic signed [COORD_W-1:0] px, py, pz,
      input logic [1:0] sx, sy, sz);
    logic signed [COORD_W-1:0] pt [NUM_AXES];
    logic [1:0]                sd [NUM_AXES];
    logic signed [COORD_W-1:0] bound;
    logic signed [COORD_W:0]   gap;
    logic [COORD_W:0]          mag;
    logic [2*COORD_W+3:0]      sq_sum;
    logic [COORD_W+1:0]        root;
    logic [COORD_W+1:0]        trial;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    sd[0] = sx;
    sd[1] = sy;
    sd[2] = sz;
    sq_sum = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      // the reserved code counts as center
      if (sd[a] == SIDE_MINUS || sd[a] == SIDE_PLUS) begin
        bound = (sd[a] == SIDE_MINUS) ? box_bound[a] : box_bound[a + NUM_AXES];
        gap = {pt[a][COORD_W-1], pt[a]} - {bound[COORD_W-1], bound};
        mag = gap[COORD_W] ? -gap : gap;
        sq_sum = sq_sum + mag * mag;
      end
    end
    root = '0;
    for (int b = COORD_W + 1; b >= 0; b--) begin
      trial = root;
      trial[b] = 1'b1;
      if (trial * trial <= sq_sum) root = trial;
    end
    return root[COORD_W:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] anchor);
    case ($urandom_range(7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return $urandom;
      default: return anchor + COORD_W'($urandom_range(0, 2**21)) - COORD_W'(2**20);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_bound();
    case ($urandom_range(7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return $urandom;
      default: return COORD_W'($urandom_range(0, 2**22)) - COORD_W'(2**21);
    endcase
  endfunction

  task automatic send_probe(input logic signed [COORD_W-1:0] px, py, pz,
                            input logic [1:0] sx, sy, sz);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    in_side_x  <= sx;
    in_side_y  <= sy;
    in_side_z  <= sz;
    do @(posedge clk); while (in_stall);
    expected_dist_q.push_back(box_feature_distance(px, py, pz, sx, sy, sz));
    items_sent++;
  endtask

  task automatic send_random_probe();
    logic signed [COORD_W-1:0] p [NUM_AXES];
    logic [1:0]                s [NUM_AXES];
    for (int a = 0; a < NUM_AXES; a++) begin
      s[a] = 2'($urandom_range(3));
      p[a] = pick_coord(box_bound[a + NUM_AXES * $urandom_range(1)]);
    end
    send_probe(p[0], p[1], p[2], s[0], s[1], s[2]);
  endtask

  task automatic set_box_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_BOX_REGS) box_bound[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_reset_box();
    send_probe(FX_HALF, FX_HALF, FX_HALF, SIDE_CENTER, SIDE_CENTER, SIDE_CENTER);
    send_probe(3 * FX_ONE, 3 * FX_ONE, 3 * FX_ONE,
               SIDE_RESERVED, SIDE_RESERVED, SIDE_RESERVED);
    // one face per axis
    send_probe(-2 * FX_ONE, FX_HALF, FX_HALF, SIDE_MINUS, SIDE_CENTER, SIDE_CENTER);
    send_probe(FX_HALF, 7 * FX_HALF, FX_HALF, SIDE_CENTER, SIDE_PLUS, SIDE_CENTER);
    send_probe(FX_HALF, FX_HALF, -FX_QUART, SIDE_CENTER, SIDE_CENTER, SIDE_MINUS);
    // edges
    send_probe(2 * FX_ONE, -FX_ONE, FX_HALF, SIDE_PLUS, SIDE_MINUS, SIDE_CENTER);
    send_probe('0, 4 * FX_ONE, 5 * FX_ONE, SIDE_CENTER, SIDE_PLUS, SIDE_PLUS);
    // corners, then points at the ends of the coordinate range
    send_probe(-FX_ONE, -FX_ONE, -FX_ONE, SIDE_MINUS, SIDE_MINUS, SIDE_MINUS);
    send_probe(4 * FX_ONE, 5 * FX_ONE, 6 * FX_ONE, SIDE_PLUS, SIDE_PLUS, SIDE_PLUS);
    send_probe(COORD_MIN, '0, '0, SIDE_MINUS, SIDE_CENTER, SIDE_CENTER);
    send_probe('0, COORD_MAX, '0, SIDE_CENTER, SIDE_PLUS, SIDE_CENTER);
    send_probe(2 * FX_ONE, 2 * FX_ONE, COORD_MIN, SIDE_PLUS, SIDE_PLUS, SIDE_RESERVED);
    // point inside the box, gaps of both signs
    send_probe(FX_QUART, 3 * FX_QUART, FX_HALF, SIDE_MINUS, SIDE_PLUS, SIDE_MINUS);
    wait_idle();
  endtask

  task automatic test_box_extremes();
    // inverted box at the far ends of the range
    for (int a = 0; a < NUM_AXES; a++) begin
      set_box_reg(CFG_IDX_BITS'(a), COORD_MAX);
      set_box_reg(CFG_IDX_BITS'(a + NUM_AXES), COORD_MIN);
    end
    box_settings++;
    send_probe(COORD_MIN, COORD_MIN, COORD_MIN, SIDE_MINUS, SIDE_MINUS, SIDE_MINUS);
    send_probe(COORD_MAX, COORD_MAX, COORD_MAX, SIDE_PLUS, SIDE_PLUS, SIDE_PLUS);
    send_probe(COORD_MIN, COORD_MAX, '0, SIDE_MINUS, SIDE_PLUS, SIDE_CENTER);
    send_probe('0, '0, '0, SIDE_MINUS, SIDE_CENTER, SIDE_PLUS);
    wait_idle();
    // writes past the last register must not land anywhere
    set_box_reg(CFG_IDX_SPARE_LO, '1);
    set_box_reg(CFG_IDX_SPARE_HI, '0);
    send_probe(COORD_MIN, '0, COORD_MAX, SIDE_MINUS, SIDE_CENTER, SIDE_PLUS);
    wait_idle();
    for (int a = 0; a < NUM_AXES; a++) begin
      set_box_reg(CFG_IDX_BITS'(a), COORD_MIN);
      set_box_reg(CFG_IDX_BITS'(a + NUM_AXES), COORD_MAX);
    end
    box_settings++;
    send_probe('0, '0, '0, SIDE_PLUS, SIDE_PLUS, SIDE_PLUS);
    send_probe(COORD_MIN, COORD_MAX, '0, SIDE_MINUS, SIDE_PLUS, SIDE_MINUS);
    wait_idle();
  endtask

  task automatic test_random(input int n_boxes, input int n_points,
                             input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (n_boxes) begin
      for (int r = 0; r < NUM_BOX_REGS; r++) set_box_reg(CFG_IDX_BITS'(r), pick_bound());
      box_settings++;
      repeat (n_points) send_random_probe();
      wait_idle();
    end
  endtask

  // output held off long enough that the pipeline fills and stalls its input
  task automatic test_output_hold();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_pending   = 1'b1;
    repeat (HOLD_CYCLES / 2) send_random_probe();
    wait_idle();
  endtask

  initial begin : out_stall_drive
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dist_q.size() == 0) begin
        $error("result word with no pending point: feature_distance %0d",
               out_feature_distance);
        fail_count++;
      end else begin
        dist_want = expected_dist_q.pop_front();
        if (out_feature_distance !== dist_want) begin
          $error("feature_distance: expected %0d, actual %0d",
                 dist_want, out_feature_distance);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    for (int a = 0; a < NUM_AXES; a++) begin
      box_bound[a] = '0;
      box_bound[a + NUM_AXES] = FX_ONE;
    end
    box_settings   = 1;
    send_gap_pct   = 13;
    recv_stall_pct = 58;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_box();
    test_box_extremes();
    test_random(3, 195, 13, 58);
    test_random(3, 195, 58, 13);
    test_random(3, 195, 0, 0);
    test_output_hold();

    if (expected_dist_q.size() != 0) begin
      $error("%0d expected distances never came out", expected_dist_q.size());
      fail_count += expected_dist_q.size();
    end
    $display("%0d points over %0d box settings, %0d distances checked",
             items_sent, box_settings, results_checked);
    $display("gaps and stalls on both sides, one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/psbfd_pkg.sv
rtl/psbfd_regs.sv
rtl/psbfd_front.sv
rtl/psbfd_sqrt_stage.sv
rtl/point_to_box_feature_distance.sv
tb/sv/testbench.sv
